// File: src/rfid_125khz_frame_decoder_defines.svh
// assertion macros for the rfid 125 khz frame decoder
// used by the top level; expects clk and rst_n in scope
`ifndef RFID_125KHZ_FRAME_DECODER_DEFINES_SVH
`define RFID_125KHZ_FRAME_DECODER_DEFINES_SVH

`ifndef SYNTHESIS
`define RFID125_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rfid125 assertion failed");
`define RFID125_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rfid125 assertion failed");
`else
`define RFID125_ASSERT_IMP(lbl, ante, cons)
`define RFID125_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: src/rfid125_pkg.sv
// shared constants, types and hex decode for the rfid 125 khz frame decoder
// no dependencies
package rfid125_pkg;

  localparam logic [7:0]  START_BYTE       = 8'h02;
  localparam logic [7:0]  END_BYTE         = 8'h03;
  localparam logic [15:0] DEFAULT_TIMEOUT  = 16'd4000;
  localparam logic [5:0]  FRAME_CHARS      = 6'd12;
  localparam logic [2:0]  CHECK_BYTE_INDEX = 3'd5;
  localparam logic [6:0]  MAX_FRAME_CHARS  = 7'd32;
  localparam logic [15:0] ELAPSED_SAT      = 16'hFFFF;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_TICK = 1'b1
  } command_t;

  typedef struct packed {
    logic        emit;
    logic [31:0] tag;
  } result_t;

  // bit 4 set means not a hex character
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) begin
      v = {1'b0, c[3:0]};
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      v = {1'b0, c[3:0] + 4'd9};
    end
    return v;
  endfunction

endpackage

// File: src/rfid125_frame.sv
// frame state, hex decode, checksum and repeat suppression
// depends on rfid125_pkg
module rfid125_frame (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   step,
  input  rfid125_pkg::command_t  command,
  input  logic [7:0]             rx_byte,
  input  logic [15:0]            timeout_ms,
  output rfid125_pkg::result_t   res
);

  logic [5:0]  char_count_r, char_count_nxt;
  logic        in_frame_r, in_frame_nxt;
  logic        frame_bad_r, frame_bad_nxt;
  logic [3:0]  high_nibble_r, high_nibble_nxt;
  logic [7:0]  running_xor_r, running_xor_nxt;
  logic [31:0] tag_accum_r, tag_accum_nxt;
  logic [7:0]  received_check_r, received_check_nxt;
  logic [31:0] previous_tag_r, previous_tag_nxt;
  logic [15:0] elapsed_ms_r, elapsed_ms_nxt;

  logic [4:0]  hv;
  logic [7:0]  b;
  logic [2:0]  idx;
  logic        frame_ok;
  logic        repeat_tag;

  always_comb begin
    char_count_nxt     = char_count_r;
    in_frame_nxt       = in_frame_r;
    frame_bad_nxt      = frame_bad_r;
    high_nibble_nxt    = high_nibble_r;
    running_xor_nxt    = running_xor_r;
    tag_accum_nxt      = tag_accum_r;
    received_check_nxt = received_check_r;
    previous_tag_nxt   = previous_tag_r;
    elapsed_ms_nxt     = elapsed_ms_r;
    res.emit           = 1'b0;
    res.tag            = tag_accum_r;

    hv  = rfid125_pkg::hex_value(rx_byte);
    b   = {high_nibble_r, hv[3:0]};
    idx = char_count_r[3:1];

    frame_ok = !frame_bad_r && (char_count_r == rfid125_pkg::FRAME_CHARS) &&
               (running_xor_r == received_check_r) && (tag_accum_r != 32'd0);
    repeat_tag = (elapsed_ms_r < timeout_ms) && (tag_accum_r == previous_tag_r);

    if (command == rfid125_pkg::CMD_TICK) begin
      if (elapsed_ms_r != rfid125_pkg::ELAPSED_SAT) begin
        elapsed_ms_nxt = elapsed_ms_r + 16'd1;
      end
    end else if (rx_byte == rfid125_pkg::START_BYTE) begin
      char_count_nxt     = 6'd0;
      frame_bad_nxt      = 1'b0;
      high_nibble_nxt    = 4'd0;
      running_xor_nxt    = 8'd0;
      tag_accum_nxt      = 32'd0;
      received_check_nxt = 8'd0;
      in_frame_nxt       = 1'b1;
    end else if (in_frame_r) begin
      if (rx_byte == rfid125_pkg::END_BYTE) begin
        in_frame_nxt = 1'b0;
        if (frame_ok) begin
          elapsed_ms_nxt = 16'd0;
          if (!repeat_tag) begin
            previous_tag_nxt = tag_accum_r;
            res.emit         = 1'b1;
          end
        end
      end else begin
        if (hv[4]) begin
          frame_bad_nxt = 1'b1;
        end else if (char_count_r < rfid125_pkg::FRAME_CHARS) begin
          if (!char_count_r[0]) begin
            high_nibble_nxt = hv[3:0];
          end else if (idx < rfid125_pkg::CHECK_BYTE_INDEX) begin
            running_xor_nxt = running_xor_r ^ b;
            if (idx != 3'd0) begin
              tag_accum_nxt = {tag_accum_r[23:0], b};
            end
          end else begin
            received_check_nxt = b;
          end
        end
        char_count_nxt = char_count_r + 6'd1;
        if (({1'b0, char_count_nxt} + 7'd1) >= rfid125_pkg::MAX_FRAME_CHARS) begin
          in_frame_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_count_r     <= 6'd0;
      in_frame_r       <= 1'b0;
      frame_bad_r      <= 1'b0;
      high_nibble_r    <= 4'd0;
      running_xor_r    <= 8'd0;
      tag_accum_r      <= 32'd0;
      received_check_r <= 8'd0;
      previous_tag_r   <= 32'd0;
      elapsed_ms_r     <= rfid125_pkg::ELAPSED_SAT;
    end else if (step) begin
      char_count_r     <= char_count_nxt;
      in_frame_r       <= in_frame_nxt;
      frame_bad_r      <= frame_bad_nxt;
      high_nibble_r    <= high_nibble_nxt;
      running_xor_r    <= running_xor_nxt;
      tag_accum_r      <= tag_accum_nxt;
      received_check_r <= received_check_nxt;
      previous_tag_r   <= previous_tag_nxt;
      elapsed_ms_r     <= elapsed_ms_nxt;
    end
  end

endmodule

// File: src/rfid_125khz_frame_decoder.sv
// a word is registered in the input register on accept; once it advances, its tag,
// if any, is loaded into the result register that drives out_valid
// throughput: one word per cycle; only a waiting result held by out_stall
// backs up the input register
// reset: synchronous active low; clears frame state, timeout back to 4000 ms,
// elapsed time saturated so the first good tag is always sent
`include "rfid_125khz_frame_decoder_defines.svh"
module rfid_125khz_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_tag_id,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_same_tag_timeout_ms
);

  logic                  in_valid_r;
  rfid125_pkg::command_t in_command_r;
  logic [7:0]            in_rx_byte_r;
  logic [15:0]           timeout_r;
  logic                  out_valid_r;
  logic [31:0]           out_tag_r;
  logic                  advance;
  rfid125_pkg::result_t  res;

  rfid125_frame u_frame (
    .clk        (clk),
    .rst_n      (rst_n),
    .step       (advance),
    .command    (in_command_r),
    .rx_byte    (in_rx_byte_r),
    .timeout_ms (timeout_r),
    .res        (res)
  );

  // held word moves on unless it makes a tag and the result register is blocked
  assign advance   = in_valid_r && (!res.emit || !out_valid_r || !out_stall);
  assign in_stall  = in_valid_r && !advance;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_tag_id = out_tag_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (!in_stall) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_command_r <= rfid125_pkg::command_t'(in_command);
      in_rx_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= rfid125_pkg::DEFAULT_TIMEOUT;
    end else if (cfg_valid && cfg_ready) begin
      timeout_r <= cfg_same_tag_timeout_ms;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance && res.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.emit) begin
      out_tag_r <= res.tag;
    end
  end

  `RFID125_ASSERT_IMP(a_tag_nonzero, out_valid_r, out_tag_r != 32'd0)
  `RFID125_ASSERT_NXT(a_emit_lands, advance && res.emit, out_valid_r && out_tag_r == $past(res.tag))
  `RFID125_ASSERT_NXT(a_taken_drops, out_valid_r && !out_stall && !(advance && res.emit), !out_valid_r)
  `RFID125_ASSERT_IMP(a_stall_only_full, in_stall, in_valid_r && res.emit && out_valid_r)

endmodule
